/* rtl/core/lscm_pkg.sv */
package lscm_pkg;

  localparam int FIELD_W    = 11;
  localparam int INDEX_W    = 6;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIST_W     = 8;
  localparam int GAP_W      = 12;
  localparam int RECIP_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_RECIP      = 2'd2;

  localparam logic [DIST_W-1:0]  DISTANCE_LIMIT_RST = 8'd5;
  localparam logic [GAP_W-1:0]   ENDPOINT_GAP_RST   = 12'd70;
  localparam logic [RECIP_W-1:0] ANGLE_RECIP_RST    = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;    // latch the new segment, restart the scan
    logic issue;    // read the next cluster slot
    logic flush;    // drop everything still in the compare pipeline
    logic capture;  // keep the matching cluster and its merged segment
    logic commit;   // update the table and load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_empty;
    logic hit_valid;
  } sts_t;

endpackage

/* rtl/core/lscm_ram.sv */
module lscm_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/lscm_ctrl.sv */
module lscm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lscm_pkg::cmd_t cmd_o,
  input  lscm_pkg::sts_t sts_i
);
  import lscm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit_valid) begin
          cmd_o.capture = 1'b1;
          cmd_o.flush   = 1'b1;
          state_d       = ST_WRITE;
        end else if (sts_i.scan_done && sts_i.pipe_empty) begin
          state_d = ST_WRITE;
        end else begin
          cmd_o.issue = !sts_i.scan_done;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/lscm_datapath.sv */
module lscm_datapath #(
  parameter int MAX_CLUSTERS = 64,
  parameter int COORD_BITS   = 11
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lscm_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lscm_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   frame_start_i,
  input  logic [lscm_pkg::FIELD_W-1:0]           seg_x_first_i,
  input  logic [lscm_pkg::FIELD_W-1:0]           seg_y_first_i,
  input  logic [lscm_pkg::FIELD_W-1:0]           seg_x_second_i,
  input  logic [lscm_pkg::FIELD_W-1:0]           seg_y_second_i,
  input  lscm_pkg::cmd_t                         cmd_i,
  output lscm_pkg::sts_t                         sts_o,
  output logic [lscm_pkg::INDEX_W-1:0]           cluster_index_o,
  output logic                                   merged_o,
  output logic                                   dropped_o,
  output logic [lscm_pkg::FIELD_W-1:0]           out_x_start_o,
  output logic [lscm_pkg::FIELD_W-1:0]           out_y_start_o,
  output logic [lscm_pkg::FIELD_W-1:0]           out_x_end_o,
  output logic [lscm_pkg::FIELD_W-1:0]           out_y_end_o
);
  import lscm_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;
  localparam int PW   = 2 * C + 3;
  localparam int UW   = 2 * C + 2;
  localparam int GW   = 2 * C + 1;
  localparam int MW   = 4 * C + 4;
  localparam int LW   = UW + 2 * DIST_W;
  localparam int CMPW = (MW > LW) ? MW : LW;
  localparam int SRW  = UW + RECIP_W;
  localparam int GLW  = (GW > 2 * GAP_W) ? GW : 2 * GAP_W;
  localparam int VW   = (C > DIST_W) ? C : DIST_W;
  localparam int IW   = $clog2(MAX_CLUSTERS);
  localparam int CW   = $clog2(MAX_CLUSTERS + 1);
  localparam int EW   = 4 * C;

  function automatic logic [C-1:0] absd(input logic [C-1:0] a, input logic [C-1:0] b);
    absd = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [UW-1:0] mag(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] n;
    n   = -v;
    mag = v[PW-1] ? UW'(n) : UW'(v);
  endfunction

  // Configuration and squared limits.
  logic [DIST_W-1:0]    dist_q;
  logic [GAP_W-1:0]     gap_q;
  logic [RECIP_W-1:0]   recip_q;
  logic [2*DIST_W-1:0]  dl2_q;
  logic [2*GAP_W-1:0]   gl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= DISTANCE_LIMIT_RST;
      gap_q   <= ENDPOINT_GAP_RST;
      recip_q <= ANGLE_RECIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DISTANCE_LIMIT: dist_q  <= cfg_data_i[DIST_W-1:0];
        REG_ENDPOINT_GAP:   gap_q   <= cfg_data_i[GAP_W-1:0];
        REG_ANGLE_RECIP:    recip_q <= cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // New segment, ordered so that x rises (y rises for a vertical one).
  logic [C-1:0] ax, ay, bx, by;
  logic [C-1:0] o_nx1, o_ny1, o_nx2, o_ny2;
  logic [C-1:0] nx1_q, ny1_q, nx2_q, ny2_q;
  logic signed [DW-1:0] an_q, bn_q;
  logic vert_q;

  assign ax = C'(seg_x_first_i);
  assign ay = C'(seg_y_first_i);
  assign bx = C'(seg_x_second_i);
  assign by = C'(seg_y_second_i);

  always_comb begin
    if (ax == bx) begin
      o_nx1 = ax;
      o_nx2 = bx;
      o_ny1 = (ay < by) ? ay : by;
      o_ny2 = (ay < by) ? by : ay;
    end else if (ax < bx) begin
      o_nx1 = ax; o_ny1 = ay; o_nx2 = bx; o_ny2 = by;
    end else begin
      o_nx1 = bx; o_ny1 = by; o_nx2 = ax; o_ny2 = ay;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      nx1_q  <= o_nx1;
      ny1_q  <= o_ny1;
      nx2_q  <= o_nx2;
      ny2_q  <= o_ny2;
      an_q   <= $signed({1'b0, o_ny1}) - $signed({1'b0, o_ny2});
      bn_q   <= $signed({1'b0, o_nx2}) - $signed({1'b0, o_nx1});
      vert_q <= (o_nx1 == o_nx2);
      dl2_q  <= dist_q * dist_q;
      gl2_q  <= gap_q * gap_q;
    end
  end

  // Table fill count and scan pointer.
  logic [CW-1:0] count_q, scan_q;
  logic          hit_q;
  logic [IW-1:0] slot_q;
  logic          full;

  assign full = (count_q == CW'(MAX_CLUSTERS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_q <= '0;
        hit_q  <= 1'b0;
        if (frame_start_i) begin
          count_q <= '0;
        end
      end else if (cmd_i.issue) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.capture) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.commit && !hit_q && !full) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Cluster memory: x start, y start, x end, y end from the low bits up.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [C-1:0]  res_x1_q, res_y1_q, res_x2_q, res_y2_q;

  assign ram_we    = cmd_i.commit && (hit_q || !full);
  assign ram_waddr = hit_q ? slot_q : count_q[IW-1:0];
  assign ram_wdata = hit_q ? {res_y2_q, res_x2_q, res_y1_q, res_x1_q}
                           : {ny2_q, nx2_q, ny1_q, nx1_q};

  lscm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CLUSTERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Compare pipeline: read, then four register stages.
  logic          vr_q, v1_q, v2_q, v3_q, v4_q;
  logic [IW-1:0] ir_q, i1_q, i2_q, i3_q, i4_q;
  logic [EW-1:0] c1_q, c2_q, c3_q, c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (cmd_i.flush) begin
      vr_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      vr_q <= cmd_i.issue;
      v1_q <= vr_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  logic [C-1:0] ox1, oy1, ox2, oy2;
  logic signed [DW-1:0] ao_c, bo_c;

  assign ox1  = ram_rdata[C-1:0];
  assign oy1  = ram_rdata[2*C-1:C];
  assign ox2  = ram_rdata[3*C-1:2*C];
  assign oy2  = ram_rdata[4*C-1:3*C];
  assign ao_c = $signed({1'b0, oy1}) - $signed({1'b0, oy2});
  assign bo_c = $signed({1'b0, ox2}) - $signed({1'b0, ox1});

  // Stage 1: slope cross products, line constant halves and endpoint gaps.
  logic signed [PW-1:0] s1_aobn_q, s1_boan_q, s1_bnbo_q, s1_x1y2_q, s1_x2y1_q;
  logic signed [PW-1:0] s1_aoao_q, s1_bobo_q;
  logic signed [DW-1:0] s1_ao_q, s1_bo_q;
  logic [C-1:0]         s1_dx_q [4];
  logic [C-1:0]         s1_dy_q [4];
  logic [C-1:0]         s1_vd_q;

  always_ff @(posedge clk_i) begin
    ir_q      <= scan_q[IW-1:0];
    i1_q      <= ir_q;
    c1_q      <= ram_rdata;
    s1_aobn_q <= PW'(ao_c * bn_q);
    s1_boan_q <= PW'(bo_c * an_q);
    s1_bnbo_q <= PW'(bn_q * bo_c);
    s1_x1y2_q <= PW'($signed({1'b0, ox1}) * $signed({1'b0, oy2}));
    s1_x2y1_q <= PW'($signed({1'b0, ox2}) * $signed({1'b0, oy1}));
    s1_aoao_q <= PW'(ao_c * ao_c);
    s1_bobo_q <= PW'(bo_c * bo_c);
    s1_ao_q   <= ao_c;
    s1_bo_q   <= bo_c;
    s1_dx_q[0] <= absd(ox1, nx1_q);
    s1_dy_q[0] <= absd(oy1, ny1_q);
    s1_dx_q[1] <= absd(ox1, nx2_q);
    s1_dy_q[1] <= absd(oy1, ny2_q);
    s1_dx_q[2] <= absd(ox2, nx1_q);
    s1_dy_q[2] <= absd(oy2, ny1_q);
    s1_dx_q[3] <= absd(ox2, nx2_q);
    s1_dy_q[3] <= absd(oy2, ny2_q);
    s1_vd_q    <= absd(nx1_q, ox1);
  end

  // Stage 2: magnitudes, norm, squared gaps and endpoint terms.
  logic signed [PW-1:0] skew_c;
  logic [UW-1:0]        s2_skew_q, s2_bnbo_q, s2_norm_q;
  logic signed [PW-1:0] s2_co_q, s2_t1_q, s2_t2_q, s2_t3_q, s2_t4_q;
  logic [GW-1:0]        s2_g_q [4];
  logic [C-1:0]         s2_vd_q;

  assign skew_c = s1_aobn_q - s1_boan_q;

  always_ff @(posedge clk_i) begin
    i2_q      <= i1_q;
    c2_q      <= c1_q;
    s2_skew_q <= mag(skew_c);
    s2_bnbo_q <= mag(s1_bnbo_q);
    s2_norm_q <= UW'(s1_aoao_q + s1_bobo_q);
    s2_co_q   <= s1_x1y2_q - s1_x2y1_q;
    s2_t1_q   <= PW'(s1_ao_q * $signed({1'b0, nx1_q}));
    s2_t2_q   <= PW'(s1_bo_q * $signed({1'b0, ny1_q}));
    s2_t3_q   <= PW'(s1_ao_q * $signed({1'b0, nx2_q}));
    s2_t4_q   <= PW'(s1_bo_q * $signed({1'b0, ny2_q}));
    for (int g = 0; g < 4; g++) begin
      s2_g_q[g] <= GW'(s1_dx_q[g] * s1_dx_q[g]) + GW'(s1_dy_q[g] * s1_dy_q[g]);
    end
    s2_vd_q   <= s1_vd_q;
  end

  // Stage 3: scaled skew, endpoint distances, gap test, distance bound.
  logic [GW-1:0] gmin_a, gmin_b, gmin;
  logic [SRW-1:0] s3_skewr_q;
  logic [UW-1:0]  s3_e1_q, s3_e2_q, s3_bnbo_q;
  logic [LW-1:0]  s3_limn_q;
  logic           s3_nz_q, s3_gok_q, s3_vok_q;

  assign gmin_a = (s2_g_q[1] < s2_g_q[0]) ? s2_g_q[1] : s2_g_q[0];
  assign gmin_b = (s2_g_q[3] < s2_g_q[2]) ? s2_g_q[3] : s2_g_q[2];
  assign gmin   = (gmin_b < gmin_a) ? gmin_b : gmin_a;

  always_ff @(posedge clk_i) begin
    i3_q       <= i2_q;
    c3_q       <= c2_q;
    s3_skewr_q <= SRW'(s2_skew_q * recip_q);
    s3_e1_q    <= mag(s2_t1_q + s2_t2_q + s2_co_q);
    s3_e2_q    <= mag(s2_t3_q + s2_t4_q + s2_co_q);
    s3_bnbo_q  <= s2_bnbo_q;
    s3_limn_q  <= LW'(dl2_q * s2_norm_q);
    s3_nz_q    <= (s2_norm_q != '0);
    s3_gok_q   <= (GLW'(gmin) <= GLW'(gl2_q));
    s3_vok_q   <= (VW'(s2_vd_q) <= VW'(dist_q));
  end

  // Stage 4: squared larger distance and the near-parallel test.
  logic [UW-1:0] em;
  logic [MW-1:0] s4_em2_q;
  logic [LW-1:0] s4_limn_q;
  logic          s4_par_q, s4_nz_q, s4_gok_q, s4_vok_q;

  assign em = (s3_e1_q > s3_e2_q) ? s3_e1_q : s3_e2_q;

  always_ff @(posedge clk_i) begin
    i4_q      <= i3_q;
    c4_q      <= c3_q;
    s4_em2_q  <= MW'(em * em);
    s4_limn_q <= s3_limn_q;
    s4_par_q  <= (s3_skewr_q <= SRW'(s3_bnbo_q));
    s4_nz_q   <= s3_nz_q;
    s4_gok_q  <= s3_gok_q;
    s4_vok_q  <= s3_vok_q;
  end

  logic hit_c;
  assign hit_c = v4_q && s4_par_q &&
                 (vert_q ? s4_vok_q
                         : (s4_nz_q && s4_gok_q && (CMPW'(s4_em2_q) <= CMPW'(s4_limn_q))));

  assign sts_o.hit_valid  = hit_c;
  assign sts_o.scan_done  = (scan_q >= count_q);
  assign sts_o.pipe_empty = !(vr_q || v1_q || v2_q || v3_q || v4_q);

  // Merged segment for the matching cluster.
  logic [C-1:0] qx1, qy1, qx2, qy2;
  logic [C-1:0] mx1, my1, mx2, my2;

  assign qx1 = c4_q[C-1:0];
  assign qy1 = c4_q[2*C-1:C];
  assign qx2 = c4_q[3*C-1:2*C];
  assign qy2 = c4_q[4*C-1:3*C];

  always_comb begin
    if (vert_q) begin
      mx1 = qx1;
      mx2 = qx2;
      my1 = (ny1_q < qy1) ? ny1_q : qy1;
      my2 = (ny2_q > qy2) ? ny2_q : qy2;
    end else begin
      mx1 = (nx1_q < qx1) ? nx1_q : qx1;
      my1 = (nx1_q < qx1) ? ny1_q : qy1;
      mx2 = (nx2_q > qx2) ? nx2_q : qx2;
      my2 = (nx2_q > qx2) ? ny2_q : qy2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q   <= i4_q;
      res_x1_q <= mx1;
      res_y1_q <= my1;
      res_x2_q <= mx2;
      res_y2_q <= my2;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      merged_o  <= hit_q;
      dropped_o <= !hit_q && full;
      if (hit_q) begin
        cluster_index_o <= INDEX_W'(slot_q);
        out_x_start_o   <= FIELD_W'(res_x1_q);
        out_y_start_o   <= FIELD_W'(res_y1_q);
        out_x_end_o     <= FIELD_W'(res_x2_q);
        out_y_end_o     <= FIELD_W'(res_y2_q);
      end else begin
        cluster_index_o <= full ? '0 : INDEX_W'(count_q);
        out_x_start_o   <= FIELD_W'(nx1_q);
        out_y_start_o   <= FIELD_W'(ny1_q);
        out_x_end_o     <= FIELD_W'(nx2_q);
        out_y_end_o     <= FIELD_W'(ny2_q);
      end
    end
  end

endmodule

/* rtl/core/line_segment_cluster_merge.sv */
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         seg_x_first, seg_y_first, seg_x_second,     frame_start
//                      seg_y_second (11 bits each), zero pad
// m_axis    out        cluster_index (6), out_x_start, out_y_start, merged, dropped
//                      out_x_end, out_y_end (11 bits each), pad
// cfg       in         cfg_idx_i selects the register, cfg_data_i is written
//
// Each segment scans the clusters held: the scan reads one table slot per cycle from the
// single read port of the cluster memory, and each slot passes through the compare pipeline.
// A match stops the scan early. Reset empties the table and loads the register
// defaults; no clearing pass is needed. A new segment is taken while the previous
// result still waits on a stalled m_axis; the write-back waits for that beat.
module line_segment_cluster_merge #(
  parameter int MAX_CLUSTERS = 64,
  parameter int COORD_BITS   = 11
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lscm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lscm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // seg_x_first, seg_y_first, seg_x_second, seg_y_second
  input  logic [lscm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // frame_start
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // cluster_index, out_x_start, out_y_start, out_x_end, out_y_end
  output logic [lscm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // merged, dropped
  output logic [1:0]                           m_axis_tuser
);
  import lscm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [INDEX_W-1:0] cluster_index;
  logic               merged, dropped;
  logic [FIELD_W-1:0] x_start, y_start, x_end, y_end;

  lscm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lscm_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .frame_start_i   (s_axis_tuser),
    .seg_x_first_i   (s_axis_tdata[FIELD_W-1:0]),
    .seg_y_first_i   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .seg_x_second_i  (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
    .seg_y_second_i  (s_axis_tdata[4*FIELD_W-1:3*FIELD_W]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cluster_index_o (cluster_index),
    .merged_o        (merged),
    .dropped_o       (dropped),
    .out_x_start_o   (x_start),
    .out_y_start_o   (y_start),
    .out_x_end_o     (x_end),
    .out_y_end_o     (y_end)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - INDEX_W - 4*FIELD_W){1'b0}},
                         y_end, x_end, y_start, x_start, cluster_index};
  assign m_axis_tuser = {dropped, merged};

endmodule

/* rtl/core/lscm_checker.sv */
module lscm_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [lscm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input logic [lscm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [lscm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input logic                                 s_axis_tuser,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [lscm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input logic [1:0]                           m_axis_tuser
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // One segment at a time: the input side closes after a beat.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a segment is in work");

  // A dropped segment is never also merged and reports slot zero.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && (m_axis_tdata[5:0] == 6'd0))
    else $error("dropped result with merge flag or slot");

  // The resulting segment always runs with rising x.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[16:6] <= m_axis_tdata[38:28]))
    else $error("result segment not ordered by x");

endmodule

bind line_segment_cluster_merge lscm_checker u_lscm_checker (.*);

/* tb/tb_line_segment_cluster_merge.sv */
module tb_line_segment_cluster_merge;
  import lscm_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic       frame_start;
    logic [10:0] x1, y1, x2, y2;
  } segment_t;

  typedef struct packed {
    logic [5:0]  index;
    logic        merged, dropped;
    logic [10:0] xs, ys, xe, ye;
  } cluster_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  line_segment_cluster_merge dut (.*);

  // Predictor state.
  logic [10:0] tab_x1 [NUM_SLOTS];
  logic [10:0] tab_y1 [NUM_SLOTS];
  logic [10:0] tab_x2 [NUM_SLOTS];
  logic [10:0] tab_y2 [NUM_SLOTS];
  int unsigned n_clusters = 0;
  logic [DIST_W-1:0]  dist_lim = DISTANCE_LIMIT_RST;
  logic [GAP_W-1:0]   gap_lim = ENDPOINT_GAP_RST;
  logic [RECIP_W-1:0] recip = ANGLE_RECIP_RST;

  segment_t pending_segs[$];
  cluster_result_t expected_clusters[$];
  segment_t on_bus;
  bit hold_sender = 1'b0;
  int burst_left = 0, gap_left = 0;
  int stall_mode = 0, stall_left = 0;
  int idle_cycles = 0;
  int n_errors = 0, n_sent = 0, n_checked = 0, n_merged = 0, n_dropped = 0, n_frames = 0;

  initial forever #10 clk_i = ~clk_i;

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sq_dist(longint px, longint py, longint qx, longint qy);
    return (px - qx) * (px - qx) + (py - qy) * (py - qy);
  endfunction

  function automatic cluster_result_t merge_segment(segment_t s);
    cluster_result_t r;
    longint nx1, ny1, nx2, ny2, rx1, ry1, rx2, ry2, an, bn;
    longint ox1, oy1, ox2, oy2, ao, bo, co, norm, e1, e2, em, lim, g, t;
    int unsigned slot;
    bit hit, drop;
    slot = 0; hit = 0; drop = 0;
    if (s.frame_start) n_clusters = 0;
    if (s.x1 == s.x2) begin
      nx1 = s.x1; nx2 = s.x2;
      ny1 = (s.y1 < s.y2) ? s.y1 : s.y2;
      ny2 = (s.y1 < s.y2) ? s.y2 : s.y1;
    end else if (s.x1 < s.x2) begin
      nx1 = s.x1; ny1 = s.y1; nx2 = s.x2; ny2 = s.y2;
    end else begin
      nx1 = s.x2; ny1 = s.y2; nx2 = s.x1; ny2 = s.y1;
    end
    an = ny1 - ny2; bn = nx2 - nx1;
    rx1 = nx1; ry1 = ny1; rx2 = nx2; ry2 = ny2;
    for (int k = 0; k < n_clusters; k++) begin
      ox1 = tab_x1[k]; oy1 = tab_y1[k]; ox2 = tab_x2[k]; oy2 = tab_y2[k];
      ao = oy1 - oy2; bo = ox2 - ox1; co = ox1 * oy2 - ox2 * oy1;
      if (absl(ao * bn - bo * an) * longint'(recip) > absl(bn * bo)) continue;
      if (bn == 0) begin
        if (absl(nx1 - ox1) <= dist_lim) begin
          rx1 = ox1; rx2 = ox2;
          ry1 = (ny1 < oy1) ? ny1 : oy1;
          ry2 = (ny2 > oy2) ? ny2 : oy2;
          hit = 1;
        end
      end else begin
        norm = ao * ao + bo * bo;
        e1 = absl(ao * nx1 + bo * ny1 + co);
        e2 = absl(ao * nx2 + bo * ny2 + co);
        em = (e1 > e2) ? e1 : e2;
        lim = longint'(dist_lim) * longint'(dist_lim);
        g = sq_dist(ox1, oy1, nx1, ny1);
        t = sq_dist(ox1, oy1, nx2, ny2); if (t < g) g = t;
        t = sq_dist(ox2, oy2, nx1, ny1); if (t < g) g = t;
        t = sq_dist(ox2, oy2, nx2, ny2); if (t < g) g = t;
        if (norm != 0 && em * em <= lim * norm && g <= longint'(gap_lim) * longint'(gap_lim)) begin
          if (nx1 < ox1) begin rx1 = nx1; ry1 = ny1; end else begin rx1 = ox1; ry1 = oy1; end
          if (nx2 > ox2) begin rx2 = nx2; ry2 = ny2; end else begin rx2 = ox2; ry2 = oy2; end
          hit = 1;
        end
      end
      if (hit) begin
        slot = k;
        break;
      end
    end
    if (hit) begin
      tab_x1[slot] = 11'(rx1); tab_y1[slot] = 11'(ry1);
      tab_x2[slot] = 11'(rx2); tab_y2[slot] = 11'(ry2);
    end else if (n_clusters < NUM_SLOTS) begin
      slot = n_clusters;
      tab_x1[slot] = 11'(nx1); tab_y1[slot] = 11'(ny1);
      tab_x2[slot] = 11'(nx2); tab_y2[slot] = 11'(ny2);
      n_clusters++;
    end else begin
      drop = 1;
    end
    r.index = 6'(slot); r.merged = hit; r.dropped = drop;
    r.xs = 11'(rx1); r.ys = 11'(ry1); r.xe = 11'(rx2); r.ye = 11'(ry2);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH beat %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_clusters = {expected_clusters, merge_segment(on_bus)};
        n_sent++;
        if (on_bus.frame_start) n_frames++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_segs.size() > 0 && !hold_sender) begin
          on_bus = pending_segs.pop_front();
          s_axis_tdata <= {4'b0, on_bus.y2, on_bus.x2, on_bus.y1, on_bus.x1};
          s_axis_tuser <= on_bus.frame_start;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus the checker and the watchdog.
  always @(posedge clk_i) begin
    cluster_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.index = m_axis_tdata[5:0];
        got.xs = m_axis_tdata[16:6];
        got.ys = m_axis_tdata[27:17];
        got.xe = m_axis_tdata[38:28];
        got.ye = m_axis_tdata[49:39];
        got.merged = m_axis_tuser[0];
        got.dropped = m_axis_tuser[1];
        if (expected_clusters.size() == 0) begin
          report_mismatch("unexpected result beats", 1, 0);
        end else begin
          want = expected_clusters.pop_front();
          if (got.index != want.index) report_mismatch("cluster_index", got.index, want.index);
          if (got.merged != want.merged) report_mismatch("merged", got.merged, want.merged);
          if (got.dropped != want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
          if (got.xs != want.xs) report_mismatch("out_x_start", got.xs, want.xs);
          if (got.ys != want.ys) report_mismatch("out_y_start", got.ys, want.ys);
          if (got.xe != want.xe) report_mismatch("out_x_end", got.xe, want.xe);
          if (got.ye != want.ye) report_mismatch("out_y_end", got.ye, want.ye);
          n_merged += want.merged;
          n_dropped += want.dropped;
        end
        n_checked++;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 300);
      end else stall_left--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready <= (stall_left % 40) < 25;
      endcase
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles with no beat", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic logic [10:0] clamp_coord(int v);
    return (v < 0) ? 11'd0 : (v > 2047) ? 11'd2047 : 11'(v);
  endfunction

  task automatic add_seg(bit fs, int x1, int y1, int x2, int y2);
    segment_t s;
    s.frame_start = fs;
    s.x1 = 11'(x1); s.y1 = 11'(y1); s.x2 = 11'(x2); s.y2 = 11'(y2);
    pending_segs = {pending_segs, s};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DISTANCE_LIMIT: dist_lim = DIST_W'(value);
      REG_ENDPOINT_GAP: gap_lim = GAP_W'(value);
      default: recip = RECIP_W'(value);
    endcase
  endtask

  task automatic drain;
    wait (pending_segs.size() == 0 && expected_clusters.size() == 0 && !s_axis_tvalid);
    repeat (80) @(posedge clk_i);
  endtask

  // Segments drawn along a few random lines of the frame, so most of them merge.
  task automatic add_line_family(int count);
    int bx[8], by[8], dx[8], dy[8];
    int lines, k, t1, t2, x1, y1, x2, y2;
    bit fs;
    lines = $urandom_range(1, 8);
    for (int i = 0; i < lines; i++) begin
      bx[i] = $urandom_range(0, 2047); by[i] = $urandom_range(0, 2047);
      dx[i] = $urandom_range(0, 4); dy[i] = int'($urandom_range(0, 8)) - 4;
    end
    for (int i = 0; i < count; i++) begin
      fs = (i == 0);
      if ($urandom_range(0, 6) == 0) begin
        add_seg(fs, $urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
      end else begin
        k = $urandom_range(0, lines - 1);
        t1 = int'($urandom_range(0, 80)) - 40;
        t2 = int'($urandom_range(0, 80)) - 40;
        x1 = clamp_coord(bx[k] + t1 * dx[k] + int'($urandom_range(0, 4)) - 2);
        y1 = clamp_coord(by[k] + t1 * dy[k] + int'($urandom_range(0, 4)) - 2);
        x2 = clamp_coord(bx[k] + t2 * dx[k] + ((dx[k] == 0) ? 0 : int'($urandom_range(0, 4)) - 2));
        y2 = clamp_coord(by[k] + t2 * dy[k] + int'($urandom_range(0, 4)) - 2);
        add_seg(fs, x1, y1, x2, y2);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, ordering, point and vertical segments, merges.
    add_seg(1, 0, 0, 2047, 2047);
    add_seg(0, 2047, 2047, 0, 0);
    add_seg(0, 2047, 0, 0, 2047);
    add_seg(0, 100, 100, 100, 100);
    add_seg(0, 300, 500, 300, 400);
    add_seg(0, 303, 450, 303, 700);
    add_seg(0, 100, 100, 100, 100);
    add_seg(0, 90, 100, 140, 100);
    add_seg(0, 400, 20, 200, 20);
    add_seg(0, 420, 22, 480, 21);
    add_seg(0, 2047, 1, 2046, 2047);
    add_seg(1, 500, 500, 500, 500);
    add_seg(0, 480, 500, 520, 500);
    add_seg(0, 10, 10, 60, 60);
    add_seg(0, 70, 70, 120, 121);
    add_seg(0, 5, 4, 200, 199);
    drain();

    // Phases under several register settings, extremes among them.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_DISTANCE_LIMIT, 0);
          write_reg(REG_ENDPOINT_GAP, 0);
          write_reg(REG_ANGLE_RECIP, 0);
        end
        2: begin
          write_reg(REG_DISTANCE_LIMIT, 255);
          write_reg(REG_ENDPOINT_GAP, 4095);
          write_reg(REG_ANGLE_RECIP, 255);
        end
        3: begin
          write_reg(REG_DISTANCE_LIMIT, 1);
          write_reg(REG_ENDPOINT_GAP, 4095);
          write_reg(REG_ANGLE_RECIP, 1);
        end
        4, 5: begin
          write_reg(REG_DISTANCE_LIMIT, $urandom_range(0, 255));
          write_reg(REG_ENDPOINT_GAP, $urandom_range(0, 4095));
          write_reg(REG_ANGLE_RECIP, $urandom_range(0, 255));
        end
        6: begin
          write_reg(REG_DISTANCE_LIMIT, 5);
          write_reg(REG_ENDPOINT_GAP, 70);
          write_reg(REG_ANGLE_RECIP, 10);
        end
        default: ;
      endcase
      for (int f = 0; f < 4; f++) add_line_family($urandom_range(15, 60));
      // Scattered segments fill the table past its end, so some are dropped.
      if (phase == 0 || phase == 3 || phase == 6) begin
        add_seg(1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
        repeat (75) add_seg(1'($urandom_range(0, 1)) & ($urandom_range(0, 60) == 0),
                            $urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
      end
      // Hold the sender once mid-phase until every result is back.
      wait (pending_segs.size() < 40);
      hold_sender = 1'b1;
      wait (expected_clusters.size() == 0 && !s_axis_tvalid);
      hold_sender = 1'b0;
      drain();
    end

    $display("covered %0d segments in %0d frames: %0d merged, %0d dropped, %0d results checked",
             n_sent, n_frames, n_merged, n_dropped, n_checked);
    $display("register sets: reset values, all zero, all maximum, two random, tight limits");
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
